/* rtl/core/ale_pkg.sv */
package ale_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 16;

    // action codes
    localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
    localparam logic [3:0] ACT_POP_BACK   = 4'd1;
    localparam logic [3:0] ACT_PUSH_FRONT = 4'd2;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd3;
    localparam logic [3:0] ACT_INSERT     = 4'd4;
    localparam logic [3:0] ACT_ERASE      = 4'd5;
    localparam logic [3:0] ACT_SORT       = 4'd6;
    localparam logic [3:0] ACT_FIND       = 4'd7;
    localparam logic [3:0] ACT_DUMP       = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // cell operations
    localparam logic [2:0] CELL_HOLD       = 3'd0;
    localparam logic [2:0] CELL_LOAD       = 3'd1;
    localparam logic [2:0] CELL_FROM_LEFT  = 3'd2;
    localparam logic [2:0] CELL_FROM_RIGHT = 3'd3;
    localparam logic [2:0] CELL_MIN_RIGHT  = 3'd4;
    localparam logic [2:0] CELL_MAX_LEFT   = 3'd5;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] din;
    } cell_ctl_t;

    typedef struct packed {
        logic [3:0]               action;
        logic [4:0]               position;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [3:0]               index;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } result_t;

endpackage

/* rtl/core/ale_cell.sv */
module ale_cell (
    input  logic                                aclk,
    input  ale_pkg::cell_ctl_t                  ctl,
    input  logic signed [ale_pkg::DATA_W-1:0]   left_val,
    input  logic signed [ale_pkg::DATA_W-1:0]   right_val,
    output logic signed [ale_pkg::DATA_W-1:0]   val
);

    logic signed [ale_pkg::DATA_W-1:0] val_reg;
    logic signed [ale_pkg::DATA_W-1:0] val_next;

    always_comb begin
        unique case (ctl.op)
            ale_pkg::CELL_LOAD:       val_next = ctl.din;
            ale_pkg::CELL_FROM_LEFT:  val_next = left_val;
            ale_pkg::CELL_FROM_RIGHT: val_next = right_val;
            // lower half of a compare-exchange pair keeps the smaller value
            ale_pkg::CELL_MIN_RIGHT:  val_next = (right_val < val_reg) ? right_val : val_reg;
            ale_pkg::CELL_MAX_LEFT:   val_next = (left_val > val_reg) ? left_val : val_reg;
            default:                  val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* rtl/core/array_list_engine.sv */
// Ordered list of up to CAPACITY signed 32-bit values, kept in a row of cells that each hold
// one entry. Push, pop, insert and erase shift all following cells at once and finish in the
// cycle the transaction is accepted, so the result is registered and ready in the next cycle.
// Sort runs CAPACITY odd-even compare-exchange phases across the cell row and then returns its
// result. Find is a binary search, one probe per cycle. Dump returns one result per entry (at
// most 16), one per cycle while the result side keeps taking them. One transaction is worked at
// a time; a new one is accepted once the previous one has delivered its results and the output
// register is empty or is being read in that same cycle.
module array_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ale_pkg::item_t   s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output ale_pkg::result_t m_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          pass_reg, pass_next;
    logic signed [CW:0]     lo_reg, lo_next;
    logic signed [CW:0]     hi_reg, hi_next;
    logic [IW-1:0]          dump_reg, dump_next;
    logic signed [ale_pkg::DATA_W-1:0] key_reg, key_next;

    logic                   m_valid_reg, m_valid_next;
    ale_pkg::result_t       m_result_reg;

    logic                   out_free;
    logic                   out_load;
    ale_pkg::result_t       out_data;
    logic                   accept;

    logic [PW-1:0]          cnt_ext;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          ins_pos;
    logic [PW-1:0]          rem_pos;
    logic                   full;
    logic                   empty;
    logic                   ins_en;
    logic                   rem_en;
    logic                   sort_en;

    logic [CW+1:0]          mid_sum;
    logic [IW-1:0]          mid;
    logic                   find_done;
    logic [IW-1:0]          rd_idx;
    logic signed [ale_pkg::DATA_W-1:0] rd_val;
    logic                   dump_last;

    logic signed [ale_pkg::DATA_W-1:0] cell_val [CAPACITY];
    ale_pkg::cell_ctl_t     cell_ctl [CAPACITY];
    logic [CAPACITY-1:0]    pair_act;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign cnt_ext = PW'(cnt_reg);
    assign pos_ext = PW'(s_item.position);
    assign full    = (cnt_ext == PW'(CAPACITY));
    assign empty   = (cnt_reg == '0);

    always_comb begin
        if (s_item.action == ale_pkg::ACT_PUSH_BACK) begin
            ins_pos = cnt_ext;
        end else if (s_item.action == ale_pkg::ACT_PUSH_FRONT) begin
            ins_pos = '0;
        end else begin
            ins_pos = pos_ext;
        end
        if (s_item.action == ale_pkg::ACT_POP_BACK) begin
            rem_pos = cnt_ext - PW'(1);
        end else if (s_item.action == ale_pkg::ACT_POP_FRONT) begin
            rem_pos = '0;
        end else begin
            rem_pos = pos_ext;
        end
    end

    // binary search probe
    assign mid_sum   = {lo_reg[CW], lo_reg} + {hi_reg[CW], hi_reg};
    assign mid       = mid_sum[IW:1];
    assign find_done = (lo_reg > hi_reg) || (rd_val == key_reg);

    assign dump_last = ((PW'(dump_reg) + PW'(1)) == cnt_ext)
                    || ((PW'(dump_reg) + PW'(1)) == PW'(ale_pkg::MAX_RESULTS));

    always_comb begin
        unique case (state_reg)
            S_FIND:  rd_idx = mid;
            S_DUMP:  rd_idx = dump_reg;
            default: rd_idx = rem_pos[IW-1:0];
        endcase
    end

    assign rd_val = cell_val[rd_idx];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        dump_next  = dump_reg;
        key_next   = key_reg;
        out_load   = 1'b0;
        out_data   = '0;
        ins_en     = 1'b0;
        rem_en     = 1'b0;
        sort_en    = 1'b0;
        out_data.last   = 1'b1;
        out_data.status = ale_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_item.action) inside
                        ale_pkg::ACT_PUSH_BACK, ale_pkg::ACT_PUSH_FRONT,
                        ale_pkg::ACT_INSERT: begin
                            out_load = 1'b1;
                            if (full) begin
                                out_data.status = ale_pkg::ST_FULL;
                            end else if (ins_pos > cnt_ext) begin
                                out_data.status = ale_pkg::ST_BADPOS;
                            end else begin
                                ins_en   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ale_pkg::ACT_POP_BACK, ale_pkg::ACT_POP_FRONT,
                        ale_pkg::ACT_ERASE: begin
                            out_load = 1'b1;
                            if (empty) begin
                                out_data.status = ale_pkg::ST_EMPTY;
                            end else if (rem_pos >= cnt_ext) begin
                                out_data.status = ale_pkg::ST_BADPOS;
                            end else begin
                                rem_en           = 1'b1;
                                cnt_next         = cnt_reg - CW'(1);
                                out_data.element = rd_val;
                            end
                        end
                        ale_pkg::ACT_SORT: begin
                            pass_next  = '0;
                            state_next = S_SORT;
                        end
                        ale_pkg::ACT_FIND: begin
                            lo_next    = '0;
                            hi_next    = $signed({1'b0, cnt_reg}) - (CW+1)'(1);
                            key_next   = s_item.value;
                            state_next = S_FIND;
                        end
                        ale_pkg::ACT_DUMP: begin
                            if (empty) begin
                                out_load        = 1'b1;
                                out_data.status = ale_pkg::ST_EMPTY;
                            end else begin
                                dump_next  = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SORT: begin
                if (PW'(pass_reg) != PW'(CAPACITY)) begin
                    sort_en   = 1'b1;
                    pass_next = pass_reg + CW'(1);
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIND: begin
                if (!find_done) begin
                    if (key_reg < rd_val) begin
                        hi_next = $signed((CW+1)'(mid)) - (CW+1)'(1);
                    end else begin
                        lo_next = $signed((CW+1)'(mid)) + (CW+1)'(1);
                    end
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (lo_reg > hi_reg) begin
                        out_data.status = ale_pkg::ST_NOTFOUND;
                    end else begin
                        out_data.index = 4'(mid);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_data.index   = 4'(dump_reg);
                    out_data.element = rd_val;
                    out_data.last    = dump_last;
                    dump_next        = dump_reg + IW'(1);
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // odd-even transposition: pair (i, i+1) is active on phases matching i's parity
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            pair_act[i] = sort_en && (PW'(i % 2) == PW'(pass_reg[0]))
                       && ((PW'(i) + PW'(1)) < cnt_ext);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].op  = ale_pkg::CELL_HOLD;
            cell_ctl[i].din = s_item.value;
            if (ins_en) begin
                if (PW'(i) == ins_pos) begin
                    cell_ctl[i].op = ale_pkg::CELL_LOAD;
                end else if ((PW'(i) > ins_pos) && (PW'(i) <= cnt_ext)) begin
                    cell_ctl[i].op = ale_pkg::CELL_FROM_LEFT;
                end
            end else if (rem_en) begin
                if ((PW'(i) >= rem_pos) && ((PW'(i) + PW'(1)) < cnt_ext)) begin
                    cell_ctl[i].op = ale_pkg::CELL_FROM_RIGHT;
                end
            end else if (pair_act[i]) begin
                cell_ctl[i].op = ale_pkg::CELL_MIN_RIGHT;
            end else if ((i > 0) && pair_act[(i > 0) ? i - 1 : 0]) begin
                cell_ctl[i].op = ale_pkg::CELL_MAX_LEFT;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ale_pkg::DATA_W-1:0] left_val;
        logic signed [ale_pkg::DATA_W-1:0] right_val;
        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_inner_l
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner_r
            assign right_val = cell_val[g+1];
        end
        ale_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[g]),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[g])
        );
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pass_reg <= pass_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        dump_reg <= dump_next;
        key_reg  <= key_next;
        if (out_load) begin
            m_result_reg <= out_data;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule
